>>> rtl/assert_macros.svh
// Assertion macros used by the swap slot allocator datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SSA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m: check failed");
`define SSA_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("%m: forbidden condition");
`else
`define SSA_ASSERT(lbl, clk, rstn, prop)
`define SSA_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> rtl/ssa_pkg.sv
// Types and constants of the swap slot allocator.
`timescale 1ns / 1ps
package ssa_pkg;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_ACCESS = 2'd2;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_NO_SPACE  = 3'd1;
    localparam logic [2:0] STS_NO_PID    = 3'd2;
    localparam logic [2:0] STS_BAD_RANGE = 3'd3;
    localparam logic [2:0] STS_NO_PAGE   = 3'd4;

    localparam logic REG_PAGE_SIZE = 1'b0;
    localparam logic REG_SLOTS     = 1'b1;

    localparam logic [12:0] PAGE_SIZE_RST = 13'd256;
    localparam logic [8:0]  SLOTS_RST     = 9'd256;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pid;
        logic [8:0]  pages_needed;
        logic [7:0]  page_number;
        logic [12:0] byte_offset;
        logic [12:0] byte_count;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  start_slot;
        logic        compacted;
        logic [20:0] address;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SRCH_INIT,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_SWEEP,
        ST_ALLOC,
        ST_END_RD,
        ST_END_CHK,
        ST_ACC_RD,
        ST_ACC_CHK,
        ST_ACC_MUL,
        ST_ACC_ADD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       capture;
        logic       scan_init;
        logic       sweep_init;
        logic       sweep_step;
        logic       srch_step;
        logic       alloc_step;
        logic       end_step;
        logic       end_finish;
        logic       acc_step;
        logic       mul;
        logic       add;
        logic       set_status;
        logic [2:0] status_code;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       pages_zero;
        logic       srch_end;
        logic       run_hit;
        logic       cnt_ovf;
        logic       scan_end;
        logic       sweep_last;
        logic       alloc_last;
        logic       found;
        logic       hit;
        logic       acc_bad;
        logic       compacted;
        logic       out_free;
    } t_sts;

endpackage

>>> rtl/ssa_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ssa_ctrl.sv
// Controller state machine of the swap slot allocator.
`timescale 1ns / 1ps
module ssa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  ssa_pkg::t_sts i_sts,
    output ssa_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    ssa_pkg::t_state r_state;
    ssa_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssa_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ssa_pkg::ST_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) n_state = ssa_pkg::ST_IDLE;
            end
            ssa_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ssa_pkg::ST_DECODE;
                end
            end
            ssa_pkg::ST_DECODE: begin
                o_cmd.scan_init = 1'b1;
                case (i_sts.kind)
                    ssa_pkg::KIND_START: begin
                        n_state = i_sts.pages_zero ? ssa_pkg::ST_DONE : ssa_pkg::ST_SRCH_RD;
                    end
                    ssa_pkg::KIND_END:    n_state = ssa_pkg::ST_END_RD;
                    ssa_pkg::KIND_ACCESS: n_state = ssa_pkg::ST_ACC_RD;
                    default:              n_state = ssa_pkg::ST_DONE;
                endcase
            end
            ssa_pkg::ST_SRCH_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state         = ssa_pkg::ST_SRCH_RD;
            end
            ssa_pkg::ST_SRCH_RD: begin
                if (i_sts.srch_end) begin
                    if (i_sts.compacted) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ssa_pkg::STS_NO_SPACE;
                        n_state           = ssa_pkg::ST_DONE;
                    end else begin
                        o_cmd.sweep_init = 1'b1;
                        n_state          = ssa_pkg::ST_SWEEP;
                    end
                end else begin
                    n_state = ssa_pkg::ST_SRCH_CHK;
                end
            end
            ssa_pkg::ST_SRCH_CHK: begin
                o_cmd.srch_step = 1'b1;
                if (i_sts.run_hit) begin
                    if (i_sts.cnt_ovf) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ssa_pkg::STS_NO_SPACE;
                        n_state           = ssa_pkg::ST_DONE;
                    end else begin
                        n_state = ssa_pkg::ST_ALLOC;
                    end
                end else begin
                    n_state = ssa_pkg::ST_SRCH_RD;
                end
            end
            ssa_pkg::ST_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) n_state = ssa_pkg::ST_SRCH_INIT;
            end
            ssa_pkg::ST_ALLOC: begin
                o_cmd.alloc_step = 1'b1;
                if (i_sts.alloc_last) n_state = ssa_pkg::ST_DONE;
            end
            ssa_pkg::ST_END_RD: begin
                if (i_sts.scan_end) begin
                    o_cmd.end_finish = 1'b1;
                    n_state          = ssa_pkg::ST_DONE;
                end else begin
                    n_state = ssa_pkg::ST_END_CHK;
                end
            end
            ssa_pkg::ST_END_CHK: begin
                o_cmd.end_step = 1'b1;
                n_state        = ssa_pkg::ST_END_RD;
            end
            ssa_pkg::ST_ACC_RD: begin
                if (i_sts.scan_end) begin
                    n_state = ssa_pkg::ST_DONE;
                    if (!i_sts.found) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ssa_pkg::STS_NO_PID;
                    end else if (i_sts.acc_bad) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ssa_pkg::STS_BAD_RANGE;
                    end else if (!i_sts.hit) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ssa_pkg::STS_NO_PAGE;
                    end else begin
                        n_state = ssa_pkg::ST_ACC_MUL;
                    end
                end else begin
                    n_state = ssa_pkg::ST_ACC_CHK;
                end
            end
            ssa_pkg::ST_ACC_CHK: begin
                o_cmd.acc_step = 1'b1;
                n_state        = ssa_pkg::ST_ACC_RD;
            end
            ssa_pkg::ST_ACC_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ssa_pkg::ST_ACC_ADD;
            end
            ssa_pkg::ST_ACC_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ssa_pkg::ST_DONE;
            end
            ssa_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ssa_pkg::ST_IDLE;
                end
            end
            default: n_state = ssa_pkg::ST_CLEAR;
        endcase
    end

    assign o_in_stall = (r_state != ssa_pkg::ST_IDLE);

endmodule

>>> rtl/ssa_dp.sv
// Datapath of the swap slot allocator: bitmap, entry list, counters, result.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ssa_dp #(
    parameter int MAX_SLOTS = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ssa_pkg::t_req i_req,
    input  logic [12:0]   i_page_size,
    input  logic [8:0]    i_slots_in_use,
    input  ssa_pkg::t_cmd i_cmd,
    output ssa_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ssa_pkg::t_rsp o_out
);

    localparam int SW = $clog2(MAX_SLOTS);
    localparam int CW = SW + 1;
    localparam int KW = (CW > 9) ? CW : 9;
    localparam int PW = SW + 13;
    localparam int AW = (PW + 1 > 21) ? PW + 1 : 21;
    localparam int TW = 24;

    ssa_pkg::t_req r_req;
    ssa_pkg::t_rsp r_res;
    ssa_pkg::t_rsp r_out;
    logic          r_out_valid;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_run;
    logic [CW-1:0] r_wr;
    logic [SW-1:0] r_alloc_slot;
    logic [7:0]    r_alloc_pg;
    logic [8:0]    r_alloc_n;
    logic          r_found;
    logic          r_hit;
    logic [SW-1:0] r_hit_slot;
    logic [PW-1:0] r_prod;

    logic          bm_we, bm_wdata, bm_rdata;
    logic [SW-1:0] bm_waddr;
    logic          tag_we;
    logic [SW-1:0] tag_waddr;
    logic [TW-1:0] tag_wdata, tag_rdata;
    logic          sl_we;
    logic [SW-1:0] sl_waddr;
    logic [SW-1:0] sl_wdata, sl_rdata;

    logic [KW-1:0] n_use;
    logic [KW-1:0] idx_k;
    logic [CW-1:0] run_next;
    logic [CW-1:0] fit_start;
    logic          pid_match;
    logic          sweep_in;
    logic [13:0]   off_w, cnt_w, ps_w;
    logic          out_free;

    // Memories: used bitmap, (pid, page) tags, slot numbers
    ssa_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_bitmap (
        .i_clk(i_clk), .i_we(bm_we), .i_waddr(bm_waddr), .i_wdata(bm_wdata),
        .i_raddr(r_idx[SW-1:0]), .o_rdata(bm_rdata)
    );
    ssa_ram #(.WIDTH(TW), .DEPTH(MAX_SLOTS)) u_tag (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(tag_waddr), .i_wdata(tag_wdata),
        .i_raddr(r_idx[SW-1:0]), .o_rdata(tag_rdata)
    );
    ssa_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_slot (
        .i_clk(i_clk), .i_we(sl_we), .i_waddr(sl_waddr), .i_wdata(sl_wdata),
        .i_raddr(r_idx[SW-1:0]), .o_rdata(sl_rdata)
    );

    // Status toward the controller
    always_comb begin
        n_use = (KW'(i_slots_in_use) < KW'(MAX_SLOTS)) ? KW'(i_slots_in_use)
                                                          : KW'(MAX_SLOTS);
        idx_k     = KW'(r_idx);
        run_next  = r_run + CW'(1);
        fit_start = r_idx - r_run;
        pid_match = (tag_rdata[23:8] == r_req.pid);
        sweep_in  = (r_idx < r_count);
        off_w     = {1'b0, r_req.byte_offset};
        cnt_w     = {1'b0, r_req.byte_count};
        ps_w      = {1'b0, i_page_size};
        out_free  = !r_out_valid || !i_out_stall;

        o_sts.kind       = r_req.kind;
        o_sts.pages_zero = (r_req.pages_needed == 9'd0);
        o_sts.srch_end   = (idx_k == n_use);
        o_sts.run_hit    = !bm_rdata && (KW'(run_next) == KW'(r_req.pages_needed));
        o_sts.cnt_ovf    = ({1'b0, KW'(r_count)} + {1'b0, KW'(r_req.pages_needed)})
                           > (KW + 1)'(MAX_SLOTS);
        o_sts.scan_end   = (r_idx == r_count);
        o_sts.sweep_last = (r_idx == CW'(MAX_SLOTS - 1));
        o_sts.alloc_last = ({1'b0, r_alloc_n} + 10'd1) == {1'b0, r_req.pages_needed};
        o_sts.found      = r_found;
        o_sts.hit        = r_hit;
        o_sts.acc_bad    = (off_w > ps_w) || (cnt_w > (ps_w - off_w));
        o_sts.compacted  = r_res.compacted;
        o_sts.out_free   = out_free;
    end

    // Memory write ports
    always_comb begin
        bm_we     = 1'b0;
        bm_waddr  = r_idx[SW-1:0];
        bm_wdata  = 1'b0;
        tag_we    = 1'b0;
        tag_waddr = r_count[SW-1:0];
        tag_wdata = {r_req.pid, r_alloc_pg};
        sl_we     = 1'b0;
        sl_waddr  = r_idx[SW-1:0];
        sl_wdata  = r_idx[SW-1:0];
        if (i_cmd.sweep_step) begin
            bm_we    = 1'b1;
            bm_wdata = sweep_in;
            sl_we    = sweep_in;
        end else if (i_cmd.alloc_step) begin
            bm_we     = 1'b1;
            bm_waddr  = r_alloc_slot;
            bm_wdata  = 1'b1;
            tag_we    = 1'b1;
            sl_we     = 1'b1;
            sl_waddr  = r_count[SW-1:0];
            sl_wdata  = r_alloc_slot;
        end else if (i_cmd.end_step) begin
            if (pid_match) begin
                bm_we    = 1'b1;
                bm_waddr = sl_rdata;
            end else begin
                tag_we    = 1'b1;
                tag_waddr = r_wr[SW-1:0];
                tag_wdata = tag_rdata;
                sl_we     = 1'b1;
                sl_waddr  = r_wr[SW-1:0];
                sl_wdata  = sl_rdata;
            end
        end
    end

    // Control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.scan_init || i_cmd.sweep_init) begin
                r_idx <= '0;
            end else if (i_cmd.sweep_step || i_cmd.srch_step || i_cmd.end_step
                         || i_cmd.acc_step) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.alloc_step) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.end_finish) begin
                r_count <= r_wr;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request, scan state and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
            r_res <= '0;
        end
        if (i_cmd.scan_init) begin
            r_run   <= '0;
            r_wr    <= '0;
            r_found <= 1'b0;
            r_hit   <= 1'b0;
        end
        if (i_cmd.sweep_init) begin
            r_res.compacted <= 1'b1;
        end
        // Advance the free run; latch the fit when it is long enough
        if (i_cmd.srch_step) begin
            r_run <= bm_rdata ? '0 : run_next;
            if (o_sts.run_hit && !o_sts.cnt_ovf) begin
                r_res.start_slot <= 8'(fit_start);
                r_alloc_slot     <= fit_start[SW-1:0];
                r_alloc_pg       <= '0;
                r_alloc_n        <= '0;
            end
        end
        if (i_cmd.alloc_step) begin
            r_alloc_slot <= r_alloc_slot + SW'(1);
            r_alloc_pg   <= r_alloc_pg + 8'd1;
            r_alloc_n    <= r_alloc_n + 9'd1;
        end
        if (i_cmd.end_step && !pid_match) begin
            r_wr <= r_wr + CW'(1);
        end
        // Keep the earliest matching page of the pid
        if (i_cmd.acc_step && pid_match) begin
            r_found <= 1'b1;
            if (!r_hit && (tag_rdata[7:0] == r_req.page_number)) begin
                r_hit      <= 1'b1;
                r_hit_slot <= sl_rdata;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_hit_slot) * PW'(i_page_size);
        end
        if (i_cmd.add) begin
            r_res.address <= 21'(AW'(r_prod) + AW'(r_req.byte_offset));
        end
        if (i_cmd.set_status) begin
            r_res.status <= i_cmd.status_code;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `SSA_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_SLOTS))
    `SSA_ASSERT(a_wr_behind, i_clk, i_rst_n, i_cmd.end_step |-> r_wr <= r_idx)
    `SSA_ASSERT(a_load_valid, i_clk, i_rst_n, i_cmd.out_load |=> r_out_valid)
    `SSA_NEVER(a_status_code, i_clk, i_rst_n, r_out_valid && (r_out.status > ssa_pkg::STS_NO_PAGE))

endmodule

>>> rtl/swap_slot_allocator_core.sv
// Swap slot allocator: first-fit contiguous slot allocation with compaction.
// Requests come in on the i_in_* channel (valid/stall) as ssa_pkg::t_req and
// each produces exactly one response on the o_out_* channel as ssa_pkg::t_rsp.
// The block works on one request at a time; o_in_stall is low only when idle.
// Each request runs through controller states; the bitmap/entry RAM read port is
// registered, so every slot or entry visited takes a read state and a check state.
//   start:  searches up to the end of the first fit, then writes one slot per page;
//           a search that fails over the usable slots is followed by compaction of
//           all MAX_SLOTS slots, a restart and a second search.
//   end:    walks the whole entry list.   access: walks the whole entry list, then
//           multiplies and adds unless it ends with an error status.
// After reset all MAX_SLOTS bitmap entries are cleared, during which no request
// is accepted; the APB registers (page_size at 0x0, slots_in_use at 0x4) are
// writable at any time and should only change while the block is idle.
// A finished response waits while the output register is held by a stalled
// receiver; the next request can be accepted in the cycle after the response is loaded.
`timescale 1ns / 1ps
module swap_slot_allocator_core #(
    parameter int MAX_SLOTS = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ssa_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ssa_pkg::t_rsp o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [12:0]   r_page_size;
    logic [8:0]    r_slots_in_use;
    ssa_pkg::t_cmd cmd;
    ssa_pkg::t_sts sts;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size    <= ssa_pkg::PAGE_SIZE_RST;
            r_slots_in_use <= ssa_pkg::SLOTS_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                ssa_pkg::REG_PAGE_SIZE: r_page_size    <= pwdata[12:0];
                ssa_pkg::REG_SLOTS:     r_slots_in_use <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[2])
            ssa_pkg::REG_PAGE_SIZE: prdata = 32'(r_page_size);
            ssa_pkg::REG_SLOTS:     prdata = 32'(r_slots_in_use);
            default:                prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    ssa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    ssa_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_in_data),
        .i_page_size    (r_page_size),
        .i_slots_in_use (r_slots_in_use),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out          (o_out_data)
    );

endmodule

>>> tb/tb.sv
// Testbench for the swap slot allocator core: directed and random requests.
`timescale 1ns / 1ps
module tb;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    ssa_pkg::t_req i_in_data;
    logic          o_out_valid;
    logic          i_out_stall;
    ssa_pkg::t_rsp o_out_data;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    swap_slot_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Slot allocator model plus the queue of responses it predicts.
    class slot_scoreboard;
        bit            used [256];
        logic [15:0]   ent_pid [256];
        logic [7:0]    ent_page [256];
        logic [8:0]    ent_slot [256];
        int            ent_cnt;
        int            page_size;
        int            slots;
        ssa_pkg::t_rsp rsp_q[$];
        int            errors;
        int            requests;
        int            responses;
        int            compactions;
        int            no_space;

        function new();
            page_size = 256;
            slots = 256;
            ent_cnt = 0;
            foreach (used[i]) used[i] = 0;
        endfunction

        function void set_reg(int idx, logic [31:0] val);
            if (idx == ssa_pkg::REG_PAGE_SIZE) page_size = val[12:0];
            else slots = val[8:0];
        endfunction

        // Lowest free run of k slots below the usable limit, or -1.
        function int first_free_run(int k);
            int n;
            int run;
            n = (slots < 256) ? slots : 256;
            run = 0;
            for (int i = 0; i < n; i++) begin
                if (used[i]) begin
                    run = 0;
                end else begin
                    run++;
                    if (run == k) return i + 1 - k;
                end
            end
            return -1;
        endfunction

        // Repack entries into slots 0..count-1 in list order.
        function void compact_entries();
            foreach (used[i]) used[i] = 0;
            for (int i = 0; i < ent_cnt; i++) begin
                ent_slot[i] = 9'(i);
                used[i] = 1;
            end
        endfunction

        function void note_request(ssa_pkg::t_req r);
            ssa_pkg::t_rsp e;
            int   s;
            int   w;
            bit   seen;
            int   hit;
            e = '0;
            requests++;
            case (r.kind)
                ssa_pkg::KIND_START: begin
                    if (r.pages_needed != 0) begin
                        s = first_free_run(r.pages_needed);
                        if (s < 0) begin
                            compact_entries();
                            e.compacted = 1'b1;
                            compactions++;
                            s = first_free_run(r.pages_needed);
                        end
                        if (s < 0 || ent_cnt + r.pages_needed > 256) begin
                            e.status = ssa_pkg::STS_NO_SPACE;
                            no_space++;
                        end else begin
                            for (int i = 0; i < r.pages_needed; i++) begin
                                ent_pid[ent_cnt] = r.pid;
                                ent_page[ent_cnt] = i[7:0];
                                ent_slot[ent_cnt] = 9'(s + i);
                                used[s + i] = 1;
                                ent_cnt++;
                            end
                            e.start_slot = s[7:0];
                        end
                    end
                end
                ssa_pkg::KIND_END: begin
                    w = 0;
                    for (int i = 0; i < ent_cnt; i++) begin
                        if (ent_pid[i] == r.pid) begin
                            used[ent_slot[i]] = 0;
                        end else begin
                            ent_pid[w] = ent_pid[i];
                            ent_page[w] = ent_page[i];
                            ent_slot[w] = ent_slot[i];
                            w++;
                        end
                    end
                    ent_cnt = w;
                end
                ssa_pkg::KIND_ACCESS: begin
                    seen = 0;
                    hit = -1;
                    for (int i = 0; i < ent_cnt; i++) begin
                        if (ent_pid[i] == r.pid) begin
                            seen = 1;
                            if (hit < 0 && ent_page[i] == r.page_number) hit = i;
                        end
                    end
                    if (!seen)
                        e.status = ssa_pkg::STS_NO_PID;
                    else if (r.byte_offset > page_size ||
                             r.byte_count > page_size - r.byte_offset)
                        e.status = ssa_pkg::STS_BAD_RANGE;
                    else if (hit < 0)
                        e.status = ssa_pkg::STS_NO_PAGE;
                    else
                        e.address = 21'(ent_slot[hit] * page_size + r.byte_offset);
                end
                default: ;
            endcase
            rsp_q.push_back(e);
        endfunction

        task report(string what, int got, int want);
            $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_response(ssa_pkg::t_rsp got);
            ssa_pkg::t_rsp e;
            responses++;
            if (rsp_q.size() == 0) begin
                report("unexpected response, status", got.status, -1);
            end else begin
                e = rsp_q.pop_front();
                if (got.status !== e.status) report("status", got.status, e.status);
                if (got.start_slot !== e.start_slot)
                    report("start_slot", got.start_slot, e.start_slot);
                if (got.compacted !== e.compacted)
                    report("compacted", got.compacted, e.compacted);
                if (got.address !== e.address) report("address", got.address, e.address);
            end
        endtask
    endclass

    slot_scoreboard sb;
    int             hold_reqs;
    int             hold_seen;
    int             hold_left;
    int             stall_mode;
    int             cyc;
    int             burst_left;
    logic [15:0]    pid_pool [8] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003,
                                     16'hFFFF, 16'h8000, 16'h1234, 16'h7FFF};
    int             ps [8] = '{256, 1, 4096, 13, 4095, 8191, 0, 100};
    int             sl [8] = '{256, 1, 8, 256, 37, 511, 0, 200};

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Check accepted responses, then pick the next stall value.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_response(o_out_data);
        if (cyc % 256 == 0) stall_mode <= $urandom_range(0, 3);
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != hold_seen) begin
            i_out_stall <= 1'b1;
            hold_left <= 3000;
            hold_seen <= hold_seen + 1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= 1'($urandom_range(0, 1));
                2: i_out_stall <= ($urandom_range(0, 9) < 8);
                default: i_out_stall <= (cyc % 4 != 0);
            endcase
        end
    end

    task send_request(ssa_pkg::t_req r);
        i_in_data <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_request(r);
    endtask

    // Send with burst and gap pacing; lower valid only for a real gap.
    task send_paced(ssa_pkg::t_req r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_request(r);
    endtask

    task drain();
        i_in_valid <= 1'b0;
        while (sb.rsp_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task write_reg(int idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx * 4);
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function ssa_pkg::t_req mk(logic [1:0] k, logic [15:0] p, int pages, int pg, int off,
                               int cnt);
        ssa_pkg::t_req r;
        r.kind = k;
        r.pid = p;
        r.pages_needed = 9'(pages);
        r.page_number = 8'(pg);
        r.byte_offset = 13'(off);
        r.byte_count = 13'(cnt);
        return r;
    endfunction

    // Mostly well-formed traffic on a small pid pool, some raw noise.
    function ssa_pkg::t_req random_request();
        ssa_pkg::t_req r;
        int   sel;
        int   off;
        r = ssa_pkg::t_req'(61'({$urandom, $urandom}));
        sel = $urandom_range(0, 99);
        r.pid = pid_pool[$urandom_range(0, 7)];
        if (sel < 35) begin
            r.kind = ssa_pkg::KIND_START;
            case ($urandom_range(0, 9))
                0: r.pages_needed = 9'($urandom_range(0, 511));
                1, 2: r.pages_needed = 9'($urandom_range(9, 48));
                default: r.pages_needed = 9'($urandom_range(1, 8));
            endcase
        end else if (sel < 75) begin
            r.kind = ssa_pkg::KIND_ACCESS;
            if ($urandom_range(0, 4) != 0) r.page_number = 8'($urandom_range(0, 12));
            if ($urandom_range(0, 4) != 0) begin
                off = (sb.page_size > 4096) ? $urandom_range(0, 8191)
                                            : $urandom_range(0, sb.page_size);
                r.byte_offset = 13'(off);
                r.byte_count = (off <= sb.page_size)
                             ? 13'($urandom_range(0, sb.page_size - off)) : 13'd0;
            end
        end else if (sel < 90) begin
            r.kind = ssa_pkg::KIND_END;
        end else if (sel < 95) begin
            r.pid = 16'($urandom);
        end else begin
            r.kind = 2'd3;
        end
        return r;
    endfunction

    initial begin
        sb = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_reqs = 0;
        hold_seen = 0;
        hold_left = 0;
        stall_mode = 0;
        cyc = 0;
        burst_left = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero pages, oversize after compaction, range checks, reuse of freed slots.
        send_request(mk(ssa_pkg::KIND_START, 16'h0000, 0, 0, 0, 0));
        send_request(mk(ssa_pkg::KIND_START, 16'h0001, 4, 0, 0, 0));
        send_request(mk(ssa_pkg::KIND_START, 16'hFFFF, 256, 0, 0, 0));
        send_request(mk(ssa_pkg::KIND_START, 16'hFFFF, 511, 0, 0, 0));
        send_request(mk(ssa_pkg::KIND_ACCESS, 16'h0001, 0, 0, 0, 256));
        send_request(mk(ssa_pkg::KIND_ACCESS, 16'h0001, 0, 3, 256, 0));
        send_request(mk(ssa_pkg::KIND_ACCESS, 16'h0001, 0, 3, 257, 0));
        send_request(mk(ssa_pkg::KIND_ACCESS, 16'h0001, 0, 3, 8191, 8191));
        send_request(mk(ssa_pkg::KIND_ACCESS, 16'h0001, 0, 1, 100, 157));
        send_request(mk(ssa_pkg::KIND_ACCESS, 16'h0001, 0, 255, 0, 0));
        send_request(mk(ssa_pkg::KIND_ACCESS, 16'hBEEF, 0, 0, 0, 0));
        send_request(mk(ssa_pkg::KIND_END, 16'hBEEF, 0, 0, 0, 0));
        send_request(mk(2'd3, 16'hFFFF, 511, 255, 8191, 8191));
        send_request(mk(ssa_pkg::KIND_END, 16'h0001, 0, 0, 0, 0));
        send_request(mk(ssa_pkg::KIND_START, 16'h000A, 100, 0, 0, 0));
        send_request(mk(ssa_pkg::KIND_START, 16'h000B, 100, 0, 0, 0));
        send_request(mk(ssa_pkg::KIND_START, 16'h000C, 56, 0, 0, 0));
        send_request(mk(ssa_pkg::KIND_END, 16'h000B, 0, 0, 0, 0));
        send_request(mk(ssa_pkg::KIND_END, 16'h000A, 0, 0, 0, 0));
        send_request(mk(ssa_pkg::KIND_START, 16'h000D, 150, 0, 0, 0));
        send_request(mk(ssa_pkg::KIND_START, 16'h000C, 2, 0, 0, 0));
        send_request(mk(ssa_pkg::KIND_ACCESS, 16'h000C, 0, 0, 5, 10));
        send_request(mk(ssa_pkg::KIND_ACCESS, 16'h000D, 0, 149, 255, 1));
        drain();

        // Random phases, each under a new register setting.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(ssa_pkg::REG_PAGE_SIZE, ps[ph]);
            write_reg(ssa_pkg::REG_SLOTS, sl[ph]);
            for (int n = 0; n < 125; n++) begin
                if (ph == 2 && n == 60) hold_reqs++;
                if (ph == 4 && n == 60) drain();
                send_paced(random_request());
            end
            drain();
        end

        repeat (2000) @(posedge i_clk);
        $display("Covered %0d requests and %0d responses over 8 register settings,",
                 sb.requests, sb.responses);
        $display("with %0d compactions and %0d no-space results.",
                 sb.compactions, sb.no_space);
        if (sb.errors == 0 && sb.rsp_q.size() == 0)
            $display("swap_slot_allocator_core test passed");
        else
            $display("swap_slot_allocator_core test failed");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("swap_slot_allocator_core test failed");
        $finish;
    end
endmodule
